// ===== src/utf8dc_pkg.sv =====
`default_nettype none

package utf8dc_pkg;

    // Number of delimiter registers and the ceiling on how many are compared
    localparam int unsigned NUM_DELIM_REGS = 4;
    localparam int unsigned MAX_DELIMITERS = 4;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_DELIM_COUNT = 3'd0;
    localparam logic [2:0] REG_DELIM_A     = 3'd1;
    localparam logic [2:0] REG_DELIM_B     = 3'd2;
    localparam logic [2:0] REG_DELIM_C     = 3'd3;
    localparam logic [2:0] REG_DELIM_D     = 3'd4;

    // Reset values of the registers
    localparam logic [2:0]  DELIM_COUNT_RST = 3'd3;
    localparam logic [15:0] DELIM_A_RST     = 16'h000A;
    localparam logic [15:0] DELIM_B_RST     = 16'h0020;
    localparam logic [15:0] DELIM_C_RST     = 16'h002C;
    localparam logic [15:0] DELIM_D_RST     = 16'h0000;

    // Character codes with special handling
    localparam logic [15:0] CHAR_NUL   = 16'h0000;
    localparam logic [15:0] CHAR_LF    = 16'h000A;
    localparam logic [15:0] CHAR_CR    = 16'h000D;
    localparam logic [15:0] CHAR_SPACE = 16'h0020;

    // Code points folded to a space
    localparam logic [30:0] SUPP_LOW  = 31'h0001_0000;
    localparam logic [30:0] SUPP_HIGH = 31'h0010_FFFF;

    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_DELIM = 2'd1,
        KIND_END   = 2'd2,
        KIND_ERROR = 2'd3
    } kind_t;

    // Input beat
    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
        logic       replace_delimiters;
    } in_beat_t;

    // Result beat
    typedef struct packed {
        kind_t       kind;
        logic [15:0] char_value;
        logic [2:0]  char_length;
    } out_beat_t;

    typedef logic [NUM_DELIM_REGS-1:0][15:0] delim_set_t;

endpackage

`default_nettype wire

// ===== src/utf8dc_classify.sv =====
`default_nettype none

// Matches a finished character against NUL and the active delimiters.
module utf8dc_classify (
    input  wire logic [15:0]              ch,
    input  wire logic [2:0]               delim_count,
    input  wire utf8dc_pkg::delim_set_t   delims,
    output logic                          is_delim
);

    logic [2:0] active;
    logic       hit;

    // Clamp the count to what can be compared
    always_comb begin
        active = delim_count;
        if (active > 3'(utf8dc_pkg::MAX_DELIMITERS)) begin
            active = 3'(utf8dc_pkg::MAX_DELIMITERS);
        end
        if (active > 3'(utf8dc_pkg::NUM_DELIM_REGS)) begin
            active = 3'(utf8dc_pkg::NUM_DELIM_REGS);
        end
    end

    // Parallel compare; CR also matches a newline delimiter
    always_comb begin
        hit = 1'b0;
        for (int i = 0; i < utf8dc_pkg::NUM_DELIM_REGS; i++) begin
            if (3'(i) < active) begin
                if (ch == delims[i] ||
                    (ch == utf8dc_pkg::CHAR_CR && delims[i] == utf8dc_pkg::CHAR_LF)) begin
                    hit = 1'b1;
                end
            end
        end
    end

    assign is_delim = (ch == utf8dc_pkg::CHAR_NUL) || hit;

endmodule

`default_nettype wire

// ===== src/utf8_decode_delimiter_classify_top.sv =====
`default_nettype none

// UTF-8 decoder with delimiter classification. Takes one byte beat per cycle
// (op=1 marks end of stream) and returns at most one result beat per input:
// a character (cut to 16 bits, code points 0x10000..0x10FFFF become a space),
// a delimiter (when replace_delimiters is set and the character is NUL or a
// configured delimiter; CR matches a newline delimiter), an end-of-stream
// marker, or a format error. Lead bytes of 1 to 6 byte sequences are handled;
// stray continuation bytes and 0xFE/0xFF are dropped. Each beat is decoded in
// the cycle it is accepted and its result lands in the output register on the
// same edge; throughput is one beat per cycle while not stalled, and the
// input only stalls when the output register is full and m_ready is low.
// Registers (APB, word addresses): 0x00 delimiter count (reset 3),
// 0x04..0x10 delimiters A..D (reset LF, space, comma, NUL).
module utf8_decode_delimiter_classify_top (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // input stream
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire utf8dc_pkg::in_beat_t   s_payload,
    // result stream
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output utf8dc_pkg::out_beat_t       m_payload,
    // configuration
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [4:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    // Configuration registers
    logic [2:0]             delim_count_reg;
    utf8dc_pkg::delim_set_t delims_reg;
    logic [2:0]             reg_index;
    logic                   cfg_write;

    // Decoder state
    logic [2:0]  rem_reg,  rem_next;
    logic [30:0] acc_reg,  acc_next;
    logic [2:0]  len_reg,  len_next;

    // Output register
    logic                  m_valid_reg;
    utf8dc_pkg::out_beat_t m_payload_reg;

    logic                  accept;
    logic                  emit;
    logic                  err;
    utf8dc_pkg::out_beat_t result;

    // Sequence completion path
    logic        fin;
    logic [30:0] fin_acc;
    logic [2:0]  fin_len;
    logic [15:0] fin_ch;
    logic        fin_delim;
    logic [30:0] acc_shift;
    logic [7:0]  c;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_count_reg <= utf8dc_pkg::DELIM_COUNT_RST;
            delims_reg[0]   <= utf8dc_pkg::DELIM_A_RST;
            delims_reg[1]   <= utf8dc_pkg::DELIM_B_RST;
            delims_reg[2]   <= utf8dc_pkg::DELIM_C_RST;
            delims_reg[3]   <= utf8dc_pkg::DELIM_D_RST;
        end else if (cfg_write) begin
            case (reg_index)
                utf8dc_pkg::REG_DELIM_COUNT: delim_count_reg <= pwdata[2:0];
                utf8dc_pkg::REG_DELIM_A:     delims_reg[0]   <= pwdata[15:0];
                utf8dc_pkg::REG_DELIM_B:     delims_reg[1]   <= pwdata[15:0];
                utf8dc_pkg::REG_DELIM_C:     delims_reg[2]   <= pwdata[15:0];
                utf8dc_pkg::REG_DELIM_D:     delims_reg[3]   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (reg_index)
            utf8dc_pkg::REG_DELIM_COUNT: prdata = {29'd0, delim_count_reg};
            utf8dc_pkg::REG_DELIM_A:     prdata = {16'd0, delims_reg[0]};
            utf8dc_pkg::REG_DELIM_B:     prdata = {16'd0, delims_reg[1]};
            utf8dc_pkg::REG_DELIM_C:     prdata = {16'd0, delims_reg[2]};
            utf8dc_pkg::REG_DELIM_D:     prdata = {16'd0, delims_reg[3]};
            default:                     prdata = 32'd0;
        endcase
    end

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign c       = s_payload.data_byte;

    assign acc_shift = {acc_reg[24:0], c[5:0]};

    // Byte decode
    always_comb begin
        rem_next = rem_reg;
        acc_next = acc_reg;
        len_next = len_reg;
        emit     = 1'b0;
        err      = 1'b0;
        fin      = 1'b0;
        fin_acc  = acc_reg;
        fin_len  = len_reg;

        if (s_payload.op) begin
            emit = 1'b1;
            if (rem_reg != 3'd0) begin
                err      = 1'b1;
                rem_next = 3'd0;
                acc_next = 31'd0;
                len_next = 3'd0;
            end
        end else if (rem_reg != 3'd0) begin
            if (c[7:6] != 2'b10) begin
                // broken sequence
                emit     = 1'b1;
                err      = 1'b1;
                rem_next = 3'd0;
                acc_next = 31'd0;
                len_next = 3'd0;
            end else begin
                acc_next = acc_shift;
                rem_next = rem_reg - 3'd1;
                if (rem_reg == 3'd1) begin
                    fin     = 1'b1;
                    fin_acc = acc_shift;
                end
            end
        end else begin
            // idle: look for a lead byte
            casez (c)
                8'b0???_????: begin
                    fin     = 1'b1;
                    fin_acc = {23'd0, c};
                    fin_len = 3'd1;
                end
                8'b110?_????: begin
                    acc_next = {26'd0, c[4:0]};
                    rem_next = 3'd1;
                    len_next = 3'd2;
                end
                8'b1110_????: begin
                    acc_next = {27'd0, c[3:0]};
                    rem_next = 3'd2;
                    len_next = 3'd3;
                end
                8'b1111_0???: begin
                    acc_next = {28'd0, c[2:0]};
                    rem_next = 3'd3;
                    len_next = 3'd4;
                end
                8'b1111_10??: begin
                    acc_next = {29'd0, c[1:0]};
                    rem_next = 3'd4;
                    len_next = 3'd5;
                end
                8'b1111_110?: begin
                    acc_next = {30'd0, c[0]};
                    rem_next = 3'd5;
                    len_next = 3'd6;
                end
                default: ;  // stray continuation, 0xFE, 0xFF
            endcase
        end

        if (fin) begin
            emit     = 1'b1;
            rem_next = 3'd0;
            acc_next = 31'd0;
            len_next = 3'd0;
        end
    end

    // Result beat assembly
    always_comb begin
        result = '{kind: utf8dc_pkg::KIND_END, char_value: 16'd0, char_length: 3'd0};
        if (err) begin
            result.kind = utf8dc_pkg::KIND_ERROR;
        end else if (fin) begin
            result.char_length = fin_len;
            if (s_payload.replace_delimiters && fin_delim) begin
                result.kind = utf8dc_pkg::KIND_DELIM;
            end else begin
                result.kind       = utf8dc_pkg::KIND_CHAR;
                result.char_value = fin_ch;
            end
        end
    end

    // Supplementary planes fold to a space
    assign fin_ch = (fin_acc >= utf8dc_pkg::SUPP_LOW && fin_acc <= utf8dc_pkg::SUPP_HIGH) ?
                    utf8dc_pkg::CHAR_SPACE : fin_acc[15:0];

    utf8dc_classify u_classify (
        .ch          (fin_ch),
        .delim_count (delim_count_reg),
        .delims      (delims_reg),
        .is_delim    (fin_delim)
    );

    // Decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= 3'd0;
            acc_reg <= 31'd0;
            len_reg <= 3'd0;
        end else if (accept) begin
            rem_reg <= rem_next;
            acc_reg <= acc_next;
            len_reg <= len_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            m_payload_reg <= result;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // Only characters carry a value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.kind != utf8dc_pkg::KIND_CHAR |-> m_payload.char_value == 16'd0)
        else $error("non-character result with nonzero value");

    // End and error carry no length
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_payload.kind == utf8dc_pkg::KIND_END ||
                    m_payload.kind == utf8dc_pkg::KIND_ERROR) |-> m_payload.char_length == 3'd0)
        else $error("end or error result with nonzero length");

    // Pending continuation count stays below the sequence length
    assert property (@(posedge aclk) disable iff (!aresetn)
        rem_reg != 3'd0 |-> rem_reg < len_reg && len_reg >= 3'd2)
        else $error("continuation count out of step with sequence length");

    // Every end marker produces a result beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_payload.op |=> m_valid)
        else $error("end marker without result");

    // Characters and delimiters always report a length
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_payload.kind == utf8dc_pkg::KIND_CHAR ||
                    m_payload.kind == utf8dc_pkg::KIND_DELIM) |-> m_payload.char_length != 3'd0)
        else $error("character result without length");

endmodule

`default_nettype wire
